// File: src/e2q_pkg.sv
// Shared constants, types and arithmetic helpers for the Euler angle to quaternion converter.
package e2q_pkg;

  localparam logic [12:0] PhaseHiBias = 13'd2070;
  localparam logic [26:0] Recip45     = 27'd95443718;
  localparam logic [26:0] TurnPerRem  = 27'd95443717;
  localparam logic [31:0] QuarterPiQ32 = 32'hC90F_DAA2;
  localparam logic [31:0] OneQ31      = 32'h8000_0000;
  localparam logic signed [32:0] OneQ30 = 33'sh0_4000_0000;

  localparam int NumSinSteps = 5;
  localparam int NumCosSteps = 6;
  localparam int StepStages  = 3;
  localparam int ChainDepth  = NumCosSteps * StepStages;
  localparam int SinCosLat   = 5 + ChainDepth + 1;
  localparam int Latency     = SinCosLat + 3;

  typedef logic signed [31:0] q30_t;

  function automatic int unsigned sin_div(input int i);
    case (i)
      0: return 110;
      1: return 72;
      2: return 42;
      3: return 20;
      default: return 6;
    endcase
  endfunction

  function automatic int unsigned cos_div(input int i);
    case (i)
      0: return 132;
      1: return 90;
      2: return 56;
      3: return 30;
      4: return 12;
      default: return 2;
    endcase
  endfunction

  // floor(v / 45), exact for v below 2^20
  function automatic logic [14:0] div45(input logic [19:0] v);
    logic [46:0] p;
    p = 47'(v) * 47'(Recip45);
    return p[46:32];
  endfunction

  // unsigned Q1.31 product, rounded
  function automatic logic [31:0] umul31(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + 64'h4000_0000;
    return p[62:31];
  endfunction

  // signed Q1.30 rescale, round half away from zero
  function automatic q30_t rnd30(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    r   = (mag + 64'h2000_0000) >> 30;
    return p[63] ? -q30_t'(r[31:0]) : q30_t'(r[31:0]);
  endfunction

  function automatic q30_t sat30(input logic signed [32:0] v);
    if (v > OneQ30) return q30_t'(OneQ30);
    if (v < -OneQ30) return q30_t'(-OneQ30);
    return q30_t'(v);
  endfunction

endpackage

// File: src/e2q_chan_if.sv
// Handshake channel interfaces for angle input and quaternion output.
interface e2q_in_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] angle_pitch;
  logic signed [31:0] angle_yaw;
  logic signed [31:0] angle_roll;

  modport source (output valid, angle_pitch, angle_yaw, angle_roll, input ready);
  modport sink   (input valid, angle_pitch, angle_yaw, angle_roll, output ready);
endinterface

interface e2q_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// File: src/e2q_sincos.sv
// Pipelined half-angle sine and cosine of one Q15.16 degree angle, Q1.30 out.
module e2q_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] angle,
  output e2q_pkg::q30_t      sin_o,
  output e2q_pkg::q30_t      cos_o
);

  localparam int Depth = e2q_pkg::ChainDepth;

  // stage 1: split phase reduction mod 45 * 2^20
  logic [12:0] hi_ofs;
  logic [14:0] hi_q, lo_q;
  logic [5:0]  rem1_nxt, lo_rem1_nxt;
  logic [5:0]  rem1_r, lo_rem1_r;
  logic [14:0] lo_q1_r;

  assign hi_ofs      = 13'({angle[31], angle[31:20]} + e2q_pkg::PhaseHiBias);
  assign hi_q        = e2q_pkg::div45({7'd0, hi_ofs});
  assign rem1_nxt    = 6'(hi_ofs - hi_q[12:0] * 13'd45);
  assign lo_q        = e2q_pkg::div45(angle[19:0]);
  assign lo_rem1_nxt = 6'(angle[19:0] - 20'(lo_q) * 20'd45);

  always_ff @(posedge clk) begin
    if (en) begin
      rem1_r    <= rem1_nxt;
      lo_rem1_r <= lo_rem1_nxt;
      lo_q1_r   <= lo_q;
    end
  end

  // stage 2: turn fraction partial terms
  logic [17:0] n2;
  logic [14:0] n2_q;
  logic [31:0] p2_nxt, p2_r;
  logic [11:0] nq2_r;
  logic [14:0] lo_q2_r;

  assign n2     = 18'(rem1_r) * 18'd31 + {lo_rem1_r, 12'd0} + 18'd22;
  assign n2_q   = e2q_pkg::div45({2'd0, n2});
  assign p2_nxt = 32'(rem1_r) * 32'(e2q_pkg::TurnPerRem);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r    <= p2_nxt;
      nq2_r   <= n2_q[11:0];
      lo_q2_r <= lo_q1_r;
    end
  end

  // stage 3: quadrant and octant fold
  logic [31:0] t3;
  logic [29:0] u3_nxt, u3_r;
  logic [1:0]  quad3_r;
  logic        swap3_r;

  assign t3     = p2_r + {5'd0, lo_q2_r, 12'd0} + {20'd0, nq2_r};
  assign u3_nxt = t3[29] ? 30'(31'h4000_0000 - {1'b0, t3[29:0]}) : t3[29:0];

  always_ff @(posedge clk) begin
    if (en) begin
      u3_r    <= u3_nxt;
      quad3_r <= t3[31:30];
      swap3_r <= t3[29];
    end
  end

  // stage 4: octant angle in radians
  logic [61:0] xm4;
  logic [30:0] x4_r;
  logic [1:0]  quad4_r;
  logic        swap4_r;

  assign xm4 = 62'(u3_r) * 62'(e2q_pkg::QuarterPiQ32) + 62'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      x4_r    <= xm4[60:30];
      quad4_r <= quad3_r;
      swap4_r <= swap3_r;
    end
  end

  // stage 5 and side delay lines
  logic [31:0] x2_5;
  logic [30:0] x_d  [Depth+1];
  logic [30:0] x2_d [Depth+1];
  logic [1:0]  qd   [Depth+1];
  logic        sd   [Depth+1];

  assign x2_5 = e2q_pkg::umul31({1'b0, x4_r}, {1'b0, x4_r});

  always_ff @(posedge clk) begin
    if (en) begin
      x_d[0]  <= x4_r;
      x2_d[0] <= x2_5[30:0];
      qd[0]   <= quad4_r;
      sd[0]   <= swap4_r;
      for (int j = 1; j <= Depth; j++) begin
        x_d[j]  <= x_d[j-1];
        x2_d[j] <= x2_d[j-1];
        qd[j]   <= qd[j-1];
        sd[j]   <= sd[j-1];
      end
    end
  end

  // Horner chains: chain 0 sine, chain 1 cosine
  logic [31:0] g_r [2][e2q_pkg::NumCosSteps];

  for (genvar c = 0; c < 2; c++) begin : g_chain
    for (genvar i = 0; i < e2q_pkg::NumCosSteps; i++) begin : g_step
      if (c == 1 || i < e2q_pkg::NumSinSteps) begin : g_on
        localparam int unsigned K = (c == 0) ? e2q_pkg::sin_div(i) : e2q_pkg::cos_div(i);
        localparam int unsigned S = 31 + $clog2(K);
        localparam logic [31:0] M = 32'((64'd1 << S) / 64'(K));
        localparam logic [31:0] Half = 32'(K / 2);

        logic [31:0] mv_nxt, mv_r, vh_r, q_r, rem, qc;
        logic [63:0] qm;

        if (i == 0) begin : g_first
          assign mv_nxt = {1'b0, x2_d[0]};
        end else begin : g_next
          assign mv_nxt = e2q_pkg::umul31({1'b0, x2_d[e2q_pkg::StepStages * i]},
                                          g_r[c][i-1]);
        end

        assign qm  = 64'(mv_r + Half) * 64'(M);
        assign rem = vh_r - q_r * K;
        assign qc  = (rem >= K) ? q_r + 32'd1 : q_r;

        always_ff @(posedge clk) begin
          if (en) begin
            mv_r      <= mv_nxt;
            vh_r      <= mv_r + Half;
            q_r       <= 32'(qm >> S);
            g_r[c][i] <= e2q_pkg::OneQ31 - qc;
          end
        end
      end
    end
  end

  // sine final product, aligned to cosine
  logic [31:0] s_r, s_d1_r, s_d2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= e2q_pkg::umul31({1'b0, x_d[e2q_pkg::StepStages * e2q_pkg::NumSinSteps]},
                                g_r[0][e2q_pkg::NumSinSteps-1]);
      s_d1_r <= s_r;
      s_d2_r <= s_d1_r;
    end
  end

  // quadrant rotation
  logic [31:0] sq, cq;
  logic [32:0] ss_w, cc_w;
  e2q_pkg::q30_t ss, cc, sin_nxt, cos_nxt, sin_r, cos_r;

  assign sq   = sd[Depth] ? g_r[1][e2q_pkg::NumCosSteps-1] : s_d2_r;
  assign cq   = sd[Depth] ? s_d2_r : g_r[1][e2q_pkg::NumCosSteps-1];
  assign ss_w = (33'(sq) + 33'd1) >> 1;
  assign cc_w = (33'(cq) + 33'd1) >> 1;
  assign ss   = e2q_pkg::q30_t'(ss_w[31:0]);
  assign cc   = e2q_pkg::q30_t'(cc_w[31:0]);

  always_comb begin
    case (qd[Depth])
      2'd0: begin
        sin_nxt = ss;
        cos_nxt = cc;
      end
      2'd1: begin
        sin_nxt = cc;
        cos_nxt = -ss;
      end
      2'd2: begin
        sin_nxt = -ss;
        cos_nxt = -cc;
      end
      default: begin
        sin_nxt = -cc;
        cos_nxt = ss;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// File: src/euler_to_quaternion.sv
// Top level: Euler angles (pitch, yaw, roll) to unit rotation quaternion.
//
// Usage:
//   in_chan  (sink)  : angle_pitch, angle_yaw, angle_roll, signed Q15.16 degrees,
//                      any value; angles wrap modulo 720 degrees.
//   out_chan (source): quat_x, quat_y, quat_z, quat_w, signed Q1.30, clamped to +/-1.
//   A transfer happens on a rising clk edge with valid and ready both high.
//   Throughput: one transfer per cycle unless stalled; each stage takes one item per cycle.
//   The 27 stages: five for phase reduction and octant fold, six three-stage
//   Horner steps (sine uses five, aligned to cosine), quadrant rotation,
//   then two multiply stages and a round/sum/clamp stage.
//   Reset (rst_n low, synchronous) clears all stage valid bits; no results are
//   pending afterwards. When out_chan.ready is low with a result waiting, the
//   whole pipeline holds and in_chan.ready drops; nothing is lost or repeated.
//   Bubbles move through normally and in_chan.ready stays high while the
//   output register is empty or being taken.
module euler_to_quaternion (
  input  logic      clk,
  input  logic      rst_n,
  e2q_in_if.sink    in_chan,
  e2q_out_if.source out_chan
);

  localparam int Lat = e2q_pkg::Latency;

  logic en;
  logic vld_r [Lat];

  assign en            = !vld_r[Lat-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < Lat; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int j = 1; j < Lat; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  e2q_pkg::q30_t sp, cp, sy, cy, sr, cr;

  e2q_sincos u_pitch (.clk(clk), .en(en), .angle(in_chan.angle_pitch), .sin_o(sp), .cos_o(cp));
  e2q_sincos u_yaw   (.clk(clk), .en(en), .angle(in_chan.angle_yaw),   .sin_o(sy), .cos_o(cy));
  e2q_sincos u_roll  (.clk(clk), .en(en), .angle(in_chan.angle_roll),  .sin_o(sr), .cos_o(cr));

  // pair products: sr*cp, cr*sp, cr*cp, sr*sp
  logic signed [63:0] pa_r [4];
  e2q_pkg::q30_t      cy1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= 64'(sr) * 64'(cp);
      pa_r[1] <= 64'(cr) * 64'(sp);
      pa_r[2] <= 64'(cr) * 64'(cp);
      pa_r[3] <= 64'(sr) * 64'(sp);
      cy1_r   <= cy;
      sy1_r   <= sy;
    end
  end

  // triple products: [k][0] times cy, [k][1] times sy
  logic signed [63:0] tp_r [4][2];
  e2q_pkg::q30_t      pr [4];

  always_comb begin
    for (int k = 0; k < 4; k++) pr[k] = e2q_pkg::rnd30(pa_r[k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        tp_r[k][0] <= 64'(pr[k]) * 64'(cy1_r);
        tp_r[k][1] <= 64'(pr[k]) * 64'(sy1_r);
      end
    end
  end

  logic signed [32:0] tr [4][2];
  e2q_pkg::q30_t qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  e2q_pkg::q30_t qx_r, qy_r, qz_r, qw_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tr[k][0] = 33'(e2q_pkg::rnd30(tp_r[k][0]));
      tr[k][1] = 33'(e2q_pkg::rnd30(tp_r[k][1]));
    end
    qx_nxt = e2q_pkg::sat30(tr[0][0] - tr[1][1]);
    qy_nxt = e2q_pkg::sat30(tr[1][0] + tr[0][1]);
    qz_nxt = e2q_pkg::sat30(tr[2][1] - tr[3][0]);
    qw_nxt = e2q_pkg::sat30(tr[2][0] + tr[3][1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      qz_r <= qz_nxt;
      qw_r <= qw_nxt;
    end
  end

  assign out_chan.valid  = vld_r[Lat-1];
  assign out_chan.quat_x = qx_r;
  assign out_chan.quat_y = qy_r;
  assign out_chan.quat_z = qz_r;
  assign out_chan.quat_w = qw_r;

endmodule
